### rtl/lrme_pkg.sv
// Package: shared types and constants of the link range mode estimator.
`default_nettype none
package lrme_pkg;

   typedef enum logic [1:0] {
      MODE_SHORT   = 2'd0,
      MODE_LONG    = 2'd1,
      MODE_NEUTRAL = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      FUNC_POLL  = 2'd0,
      FUNC_TX    = 2'd1,
      FUNC_RX    = 2'd2,
      FUNC_SPARE = 2'd3
   } func_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_THRESHOLD  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUIET_LIMIT     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAIL_LIMIT      = 2'd3;

   localparam logic [2:0] SHORT_THRESHOLD_RESET = 3'd1;
   localparam logic [2:0] LONG_THRESHOLD_RESET  = 3'd3;
   localparam logic [7:0] QUIET_LIMIT_RESET     = 8'd15;
   localparam logic [7:0] FAIL_LIMIT_RESET      = 8'd75;

   // packet count phase boundaries and saturation points
   localparam logic [7:0] INIT_COUNT = 8'd30;
   localparam logic [7:0] INTE_COUNT = 8'd200;
   localparam logic [7:0] QUIET_MAX  = 8'd255;

   typedef struct packed {
      logic [2:0] short_threshold;
      logic [2:0] long_threshold;
      logic [7:0] quiet_limit;
      logic [7:0] fail_limit;
   } cfg_type;

   typedef struct packed {
      func_type   func;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      mode_type   range_mode;
      logic [2:0] error_average;
      logic [2:0] error_weight;
      logic       tx_reconfigure;
      logic       tx_reconfigure_long;
      logic       fail_reconfigure;
   } rsp_word_type;

endpackage
`default_nettype wire

### rtl/lrme_if.sv
// Interfaces: request and response channels with valid/ready handshake.
`default_nettype none
interface lrme_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, func, data_byte, last_byte, input ready);
   modport sink (input valid, func, data_byte, last_byte, output ready);
endinterface

interface lrme_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] range_mode;
   logic [2:0] error_average;
   logic [2:0] error_weight;
   logic       tx_reconfigure;
   logic       tx_reconfigure_long;
   logic       fail_reconfigure;

   modport source (output valid, range_mode, error_average, error_weight, tx_reconfigure,
                   tx_reconfigure_long, fail_reconfigure, input ready);
   modport sink (input valid, range_mode, error_average, error_weight, tx_reconfigure,
                 tx_reconfigure_long, fail_reconfigure, output ready);
endinterface
`default_nettype wire

### rtl/lrme_csr.sv
// Configuration registers: thresholds and quiet spell limits.
`default_nettype none
module lrme_csr
   import lrme_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SHORT_THRESHOLD: cfg_in.short_threshold = csr_write_data[2:0];
            CSR_LONG_THRESHOLD:  cfg_in.long_threshold  = csr_write_data[2:0];
            CSR_QUIET_LIMIT:     cfg_in.quiet_limit     = csr_write_data[7:0];
            CSR_FAIL_LIMIT:      cfg_in.fail_limit      = csr_write_data[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_threshold <= SHORT_THRESHOLD_RESET;
         cfg_ff.long_threshold  <= LONG_THRESHOLD_RESET;
         cfg_ff.quiet_limit     <= QUIET_LIMIT_RESET;
         cfg_ff.fail_limit      <= FAIL_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

### rtl/lrme_engine.sv
// Estimator state and per-word decision logic: checksum, average, mode, quiet spells.
`default_nettype none
module lrme_engine
   import lrme_pkg::*;
#(
   parameter int HISTORY_LEN = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         enable,   // word in the input register is consumed this cycle
   input  wire req_word_type word,
   input  wire cfg_type      cfg,
   output logic              produces, // word yields a response
   output rsp_word_type      result
);

   logic [7:0] xor_ff, xor_in;
   logic [2:0] avg_ff, avg_in;
   logic [7:0] pkt_cnt_ff, pkt_cnt_in;
   mode_type   mode_ff, mode_in;
   mode_type   hist_ff [HISTORY_LEN];
   mode_type   hist_in [HISTORY_LEN];
   mode_type   last_tx_ff, last_tx_in;
   logic [7:0] quiet_ff, quiet_in;

   logic       is_rx, is_end, is_event;
   logic [7:0] cks, err;
   logic [2:0] weight;
   logic [6:0] sum_init, sum_inte, sum_late;
   logic [3:0] acc_raw;
   logic [2:0] acc;
   mode_type   pick;
   logic       all_short, all_neutral, any_long;
   logic       txr, txl, fail;

   assign is_rx    = (word.func == FUNC_RX);
   assign is_end   = is_rx && word.last_byte;
   assign is_event = (word.func == FUNC_POLL) || (word.func == FUNC_TX);
   assign produces = is_end || is_event;

   // check bits sit in [7:2] of the final byte; its mode bits fold into [3:2]
   assign cks    = (xor_ff & 8'hFC) ^ {4'd0, word.data_byte[1:0], 2'd0};
   assign err    = (word.data_byte & 8'hFC) ^ cks;
   assign weight = 3'($countones(err[7:2]));

   assign sum_init = {4'd0, avg_ff} * 7'd5  + {4'd0, weight} * 7'd3;
   assign sum_inte = {4'd0, avg_ff} * 7'd11 + {4'd0, weight} * 7'd5;
   assign sum_late = {4'd0, avg_ff} * 7'd13 + {4'd0, weight} * 7'd3;

   always_comb begin
      if (pkt_cnt_ff < INIT_COUNT) begin
         acc_raw = sum_init[6:3];
      end else if (pkt_cnt_ff < INTE_COUNT) begin
         acc_raw = {1'b0, sum_inte[6:4]};
      end else begin
         acc_raw = {1'b0, sum_late[6:4]};
      end
      acc = (acc_raw > 4'd7) ? 3'd7 : acc_raw[2:0];
   end

   always_comb begin
      if (acc <= cfg.short_threshold) begin
         pick = (word.data_byte[1:0] == MODE_SHORT && weight <= cfg.short_threshold)
                ? MODE_SHORT : MODE_NEUTRAL;
      end else if (acc > cfg.long_threshold) begin
         pick = MODE_LONG;
      end else begin
         pick = (word.data_byte[1:0] == MODE_LONG) ? MODE_LONG : MODE_NEUTRAL;
      end
   end

   always_comb begin
      all_short   = 1'b1;
      all_neutral = 1'b1;
      any_long    = 1'b0;
      for (int i = 0; i < HISTORY_LEN; i++) begin
         if (hist_ff[i] != MODE_SHORT) all_short = 1'b0;
         if (hist_ff[i] != MODE_NEUTRAL) all_neutral = 1'b0;
         if (hist_ff[i] == MODE_LONG) any_long = 1'b1;
      end
   end

   always_comb begin
      xor_in     = xor_ff;
      avg_in     = avg_ff;
      pkt_cnt_in = pkt_cnt_ff;
      mode_in    = mode_ff;
      last_tx_in = last_tx_ff;
      quiet_in   = quiet_ff;
      txr        = 1'b0;
      txl        = 1'b0;
      fail       = 1'b0;
      for (int i = 0; i < HISTORY_LEN; i++) begin
         hist_in[i] = hist_ff[i];
      end

      if (is_rx && !word.last_byte) begin
         xor_in = xor_ff ^ word.data_byte;
      end else if (produces) begin
         if (is_end) begin
            xor_in = 8'd0;
            avg_in = acc;
            case (pick)
               MODE_SHORT:
                  mode_in = (all_short || all_neutral) ? MODE_SHORT : MODE_NEUTRAL;
               MODE_LONG:
                  mode_in = any_long ? MODE_LONG : MODE_NEUTRAL;
               default:
                  mode_in = (hist_ff[0] == MODE_NEUTRAL && hist_ff[1] == MODE_NEUTRAL)
                            ? MODE_LONG : MODE_NEUTRAL;
            endcase
            if (pkt_cnt_ff < INTE_COUNT) pkt_cnt_in = pkt_cnt_ff + 8'd1;
            quiet_in = 8'd1;
         end else begin
            if (word.func == FUNC_TX) begin
               if (last_tx_ff != mode_ff && mode_ff != MODE_NEUTRAL) begin
                  txr = 1'b1;
                  txl = (mode_ff != MODE_SHORT);
               end
               last_tx_in = mode_ff;
            end
            quiet_in = (quiet_ff < QUIET_MAX) ? quiet_ff + 8'd1 : quiet_ff;
            if (mode_ff != MODE_LONG && quiet_ff > cfg.quiet_limit) begin
               mode_in = MODE_NEUTRAL;
               if (quiet_ff > cfg.fail_limit) begin
                  mode_in  = MODE_LONG;
                  fail     = 1'b1;
                  quiet_in = 8'd1;
               end
            end
         end
         for (int i = 1; i < HISTORY_LEN; i++) begin
            hist_in[i] = hist_ff[i-1];
         end
         hist_in[0] = mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xor_ff     <= 8'd0;
         avg_ff     <= 3'd0;
         pkt_cnt_ff <= 8'd0;
         mode_ff    <= MODE_SHORT;
         last_tx_ff <= MODE_NONE;
         quiet_ff   <= 8'd0;
         for (int i = 0; i < HISTORY_LEN; i++) begin
            hist_ff[i] <= MODE_SHORT;
         end
      end else if (enable) begin
         xor_ff     <= xor_in;
         avg_ff     <= avg_in;
         pkt_cnt_ff <= pkt_cnt_in;
         mode_ff    <= mode_in;
         last_tx_ff <= last_tx_in;
         quiet_ff   <= quiet_in;
         for (int i = 0; i < HISTORY_LEN; i++) begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

   always_comb begin
      result.range_mode          = mode_in;
      result.error_average       = avg_in;
      result.error_weight        = is_end ? weight : 3'd0;
      result.tx_reconfigure      = txr;
      result.tx_reconfigure_long = txl;
      result.fail_reconfigure    = fail;
   end

endmodule
`default_nettype wire

### rtl/link_range_mode_estimator.sv
// Top level: link range mode estimator with input register and response register.
//
//  channel  | dir | handshake           | word
//  ---------+-----+---------------------+------------------------------------------
//  req_bus  | in  | valid/ready         | func, data_byte, last_byte
//  rsp_bus  | out | valid/ready         | range_mode, error_average, error_weight,
//           |     |                     | tx_reconfigure(_long), fail_reconfigure
//  csr_*    | in  | write enable only   | index 0..3, 8-bit data, no read-back
//
// One word per cycle sustained while the response slot is free; the input register
// loads at the accepting edge and the response register as the word leaves it.
// The engine state updates when the word leaves the input register, so each word
// sees all effects of the one before it in the very next cycle.
// Mid-packet bytes and spare event codes produce no response and never stall.
// A stalled response holds the input register only for words that need an
// output slot; reset is synchronous and clears all control and estimator state.
`default_nettype none
module link_range_mode_estimator
   import lrme_pkg::*;
#(
   parameter int HISTORY_LEN = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   lrme_req_if.sink                    req_bus,
   lrme_rsp_if.source                  rsp_bus,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type      cfg;
   req_word_type s1_word_ff, s1_word_in;
   logic         s1_valid_ff, s1_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type result;
   logic         produces;
   logic         out_free, s1_advance, accept;

   lrme_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   lrme_engine #(
      .HISTORY_LEN (HISTORY_LEN)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .enable   (s1_advance),
      .word     (s1_word_ff),
      .cfg      (cfg),
      .produces (produces),
      .result   (result)
   );

   // the response slot frees up when empty or being taken this cycle
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign s1_advance = s1_valid_ff && (!produces || out_free);
   assign req_bus.ready = !s1_valid_ff || s1_advance;
   assign accept     = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_word_in  = s1_word_ff;
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_word_in.func      = func_type'(req_bus.func);
         s1_word_in.data_byte = req_bus.data_byte;
         s1_word_in.last_byte = req_bus.last_byte;
         s1_valid_in          = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance && produces) begin
         rsp_word_in  = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      s1_word_ff  <= s1_word_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_bus.valid               = rsp_valid_ff;
   assign rsp_bus.range_mode          = rsp_word_ff.range_mode;
   assign rsp_bus.error_average       = rsp_word_ff.error_average;
   assign rsp_bus.error_weight        = rsp_word_ff.error_weight;
   assign rsp_bus.tx_reconfigure      = rsp_word_ff.tx_reconfigure;
   assign rsp_bus.tx_reconfigure_long = rsp_word_ff.tx_reconfigure_long;
   assign rsp_bus.fail_reconfigure    = rsp_word_ff.fail_reconfigure;

endmodule
`default_nettype wire

### rtl/lrme_checker.sv
// Checker: port-level properties of the estimator, bound to the top level.
`default_nettype none
module lrme_checker
   import lrme_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] range_mode,
   input wire logic [2:0] error_average,
   input wire logic [2:0] error_weight,
   input wire logic       tx_reconfigure,
   input wire logic       tx_reconfigure_long,
   input wire logic       fail_reconfigure
);

   logic [10:0] rsp_bits;
   assign rsp_bits = {range_mode, error_average, error_weight, tx_reconfigure,
                      tx_reconfigure_long, fail_reconfigure};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bits))
      else $error("response word changed or dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_long_needs_reconf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && tx_reconfigure_long |-> tx_reconfigure)
      else $error("long target flagged without a transmit reconfigure");

   a_fail_goes_long: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fail_reconfigure |-> range_mode == MODE_LONG && error_weight == 3'd0)
      else $error("fail reconfigure without long mode");

   // a long target means the mode was long, which no quiet spell changes
   a_tx_long_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && tx_reconfigure |-> error_weight == 3'd0
                                      && (!tx_reconfigure_long || range_mode == MODE_LONG))
      else $error("transmit reconfigure to long range without long mode");

endmodule

bind link_range_mode_estimator lrme_checker u_lrme_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .range_mode          (rsp_bus.range_mode),
   .error_average       (rsp_bus.error_average),
   .error_weight        (rsp_bus.error_weight),
   .tx_reconfigure      (rsp_bus.tx_reconfigure),
   .tx_reconfigure_long (rsp_bus.tx_reconfigure_long),
   .fail_reconfigure    (rsp_bus.fail_reconfigure)
);
`default_nettype wire
